FILE: hw/rtl/bkvt_pkg.sv
`timescale 1ns / 1ps

package bkvt_pkg;

	localparam int CAPACITY   = 16;
	localparam int KEY_BITS   = 32;
	localparam int VALUE_BITS = 32;
	localparam int FUNC_BITS  = 3;
	localparam int POS_BITS   = 4;
	localparam int IDX_BITS   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_BITS   = $clog2(CAPACITY + 1);
	localparam int COUNT_BITS = 5;

	typedef logic [KEY_BITS-1:0]   key_t;
	typedef logic [VALUE_BITS-1:0] val_t;
	typedef logic [POS_BITS-1:0]   pos_t;
	typedef logic [IDX_BITS-1:0]   idx_t;
	typedef logic [CNT_BITS-1:0]   cnt_t;
	typedef logic [COUNT_BITS-1:0] count_t;

	localparam cnt_t CAP_CNT = cnt_t'(CAPACITY);
	localparam cnt_t CNT_ONE = cnt_t'(1);

	typedef enum logic [FUNC_BITS-1:0] {
		FN_INSERT     = 3'd0,
		FN_UPDATE     = 3'd1,
		FN_INS_OR_UPD = 3'd2,
		FN_ERASE      = 3'd3,
		FN_CONTAINS   = 3'd4,
		FN_GET_KEY    = 3'd5,
		FN_GET_INDEX  = 3'd6
	} func_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_ACT,
		ST_LAST,
		ST_MOVE,
		ST_POS,
		ST_GETPOS,
		ST_FIN
	} state_t;

	typedef struct packed {
		idx_t raddr;
		idx_t waddr;
		logic we_key;
		logic we_val;
		key_t wkey;
		val_t wval;
	} mem_req_t;

	typedef struct packed {
		logic   ok;
		key_t   found_key;
		val_t   found_value;
		count_t count;
	} result_t;

endpackage

FILE: hw/rtl/bkvt_store.sv
`timescale 1ns / 1ps

module bkvt_store import bkvt_pkg::*; (
	input  logic     clk,
	input  mem_req_t req,
	output key_t     rd_key,
	output val_t     rd_value
);

	key_t key_mem [CAPACITY];
	val_t val_mem [CAPACITY];

	always_ff @(posedge clk) begin
		if (req.we_key) begin
			key_mem[req.waddr] <= req.wkey;
		end
		if (req.we_val) begin
			val_mem[req.waddr] <= req.wval;
		end
		rd_key   <= key_mem[req.raddr];
		rd_value <= val_mem[req.raddr];
	end

endmodule

FILE: hw/rtl/bkvt_ctrl.sv
`timescale 1ns / 1ps

module bkvt_ctrl import bkvt_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [FUNC_BITS-1:0] func,
	input  key_t                 key,
	input  val_t                 value,
	input  pos_t                 position,
	output mem_req_t             mem_req,
	input  key_t                 rd_key,
	input  val_t                 rd_value,
	input  logic                 res_free,
	output logic                 res_load,
	output result_t              res
);

	state_t state_q, state_d;
	func_t  func_q;
	key_t   key_q;
	val_t   val_q;
	pos_t   pos_q;
	cnt_t   count_q;
	cnt_t   idx_q;
	logic   pend_q;
	idx_t   pend_idx_q;
	logic   found_q;
	idx_t   slot_q;
	logic   ok_q;
	key_t   fk_q;
	val_t   fv_q;

	logic issue, hit, room, insert_go, upd_go, pos_ok;
	cnt_t last_cnt;

	assign issue     = idx_q < count_q;
	assign hit       = (state_q == ST_SEARCH) && pend_q && (rd_key == key_q);
	assign room      = count_q < CAP_CNT;
	assign insert_go = !found_q && room &&
		((func_q == FN_INSERT) || (func_q == FN_INS_OR_UPD));
	assign upd_go    = found_q && ((func_q == FN_UPDATE) || (func_q == FN_INS_OR_UPD));
	assign pos_ok    = cnt_t'(pos_q) < count_q;
	assign last_cnt  = count_q - CNT_ONE;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					case (func_t'(func))
						FN_INSERT, FN_UPDATE, FN_INS_OR_UPD,
						FN_ERASE, FN_CONTAINS, FN_GET_KEY: state_d = ST_SEARCH;
						FN_GET_INDEX: state_d = ST_POS;
						default: state_d = ST_FIN;
					endcase
				end
			end
			ST_SEARCH: begin
				if (hit || !issue) begin
					state_d = ST_ACT;
				end
			end
			ST_ACT: begin
				if ((func_q == FN_ERASE) && found_q) begin
					state_d = ST_LAST;
				end else begin
					state_d = ST_FIN;
				end
			end
			ST_LAST:   state_d = ST_MOVE;
			ST_MOVE:   state_d = ST_FIN;
			ST_POS:    state_d = ST_GETPOS;
			ST_GETPOS: state_d = ST_FIN;
			ST_FIN: begin
				if (res_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		mem_req  = '0;
		in_ready = 1'b0;
		res_load = 1'b0;
		case (state_q)
			ST_IDLE: in_ready = 1'b1;
			ST_SEARCH: mem_req.raddr = idx_q[IDX_BITS-1:0];
			ST_ACT: begin
				if (insert_go) begin
					mem_req.waddr  = count_q[IDX_BITS-1:0];
					mem_req.we_key = 1'b1;
					mem_req.we_val = 1'b1;
					mem_req.wkey   = key_q;
					mem_req.wval   = val_q;
				end else if (upd_go) begin
					mem_req.waddr  = slot_q;
					mem_req.we_val = 1'b1;
					mem_req.wval   = val_q;
				end
			end
			ST_LAST: mem_req.raddr = last_cnt[IDX_BITS-1:0];
			ST_MOVE: begin
				// fill the freed slot with the last entry
				mem_req.waddr  = slot_q;
				mem_req.we_key = 1'b1;
				mem_req.we_val = 1'b1;
				mem_req.wkey   = rd_key;
				mem_req.wval   = rd_value;
			end
			ST_POS: mem_req.raddr = IDX_BITS'(pos_q);
			ST_FIN: res_load = res_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			idx_q   <= '0;
			pend_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: begin
					idx_q  <= '0;
					pend_q <= 1'b0;
				end
				ST_SEARCH: begin
					pend_q <= issue;
					if (issue) begin
						idx_q <= idx_q + CNT_ONE;
					end
				end
				ST_ACT: begin
					if (insert_go) begin
						count_q <= count_q + CNT_ONE;
					end
				end
				ST_MOVE: count_q <= last_cnt;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					func_q  <= func_t'(func);
					key_q   <= key;
					val_q   <= value;
					pos_q   <= position;
					found_q <= 1'b0;
					ok_q    <= 1'b0;
					fk_q    <= '0;
					fv_q    <= '0;
				end
			end
			ST_SEARCH: begin
				pend_idx_q <= idx_q[IDX_BITS-1:0];
				if (hit) begin
					found_q <= 1'b1;
					slot_q  <= pend_idx_q;
					if (func_q == FN_GET_KEY) begin
						fv_q <= rd_value;
					end
				end
			end
			ST_ACT: begin
				ok_q <= insert_go || upd_go ||
					(found_q && ((func_q == FN_CONTAINS) || (func_q == FN_GET_KEY)));
			end
			ST_MOVE: ok_q <= 1'b1;
			ST_GETPOS: begin
				if (pos_ok) begin
					ok_q <= 1'b1;
					fk_q <= rd_key;
					fv_q <= rd_value;
				end
			end
			default: ;
		endcase
	end

	assign res.ok          = ok_q;
	assign res.found_key   = fk_q;
	assign res.found_value = fv_q;
	assign res.count       = COUNT_BITS'(count_q);

endmodule

FILE: hw/rtl/bounded_key_value_table_unit.sv
`timescale 1ns / 1ps

// Channel   Dir  Signals                       Payload
// s_*       in   s_tvalid s_tready s_tdata     request: func, key, value, position
//                s_tuser
// m_*       out  m_tvalid m_tready m_tdata     result: ok, found_key, found_value, count
//                m_tuser
//
// One request at a time. A searched command makes one key compare per cycle on the
// single memory read port (ST_SEARCH), then passes ST_ACT and ST_FIN; a hit ends the
// search early. Erase of a present key adds ST_LAST and ST_MOVE to fetch and move
// the last entry. get_by_index passes ST_POS, ST_GETPOS and ST_FIN; an unused code
// goes straight to ST_FIN.
// Reset clears the entry count; the key and value memories are not cleared.
// A stalled result is held in the output register; the next request is taken
// meanwhile and only its own result waits for the register to drain.

module bounded_key_value_table_unit import bkvt_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [71:0]          s_tdata,  // key[31:0], value[63:32], position[67:64]
	input  logic [FUNC_BITS-1:0] s_tuser,  // func[2:0]
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [71:0]          m_tdata,  // found_key[31:0], found_value[63:32],
	                                       // count[68:64]
	output logic                 m_tuser   // ok[0]
);

	localparam int OUT_PAD = 72 - KEY_BITS - VALUE_BITS - COUNT_BITS;

	mem_req_t mem_req;
	key_t     rd_key;
	val_t     rd_value;
	result_t  res, out_q;
	logic     res_free, res_load, out_valid_q;

	assign res_free = !out_valid_q || m_tready;

	bkvt_store u_store (
		.clk      (clk),
		.req      (mem_req),
		.rd_key   (rd_key),
		.rd_value (rd_value)
	);

	bkvt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.func     (s_tuser),
		.key      (s_tdata[KEY_BITS-1:0]),
		.value    (s_tdata[KEY_BITS+VALUE_BITS-1:KEY_BITS]),
		.position (s_tdata[KEY_BITS+VALUE_BITS+POS_BITS-1:KEY_BITS+VALUE_BITS]),
		.mem_req  (mem_req),
		.rd_key   (rd_key),
		.rd_value (rd_value),
		.res_free (res_free),
		.res_load (res_load),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_q.ok;
	assign m_tdata  = {{OUT_PAD{1'b0}}, out_q.count, out_q.found_value, out_q.found_key};

endmodule
